// File: design/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and codes of the text console character engine: the item
// layouts of both channels, action and direction codes, character codes
// and configuration register indexes.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // Field widths of the channel items.
   localparam int ACTION_W     = 2;
   localparam int CHAR_W       = 8;
   localparam int DIR_W        = 2;
   localparam int ADDR_FIELD_W = 11;
   localparam int POS_W        = 11;
   localparam int CELL_W       = 16;
   localparam int COLOUR_W     = 4;
   localparam int CSR_INDEX_W  = 1;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACTION_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_MOVE  = 2'd2;
   localparam logic [ACTION_W-1:0] ACTION_READ  = 2'd3;

   // Cursor move directions.
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

   // Character codes with a meaning of their own.
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE  = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB        = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN     = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BLANK      = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LOW  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_HIGH = 8'h7F;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FOREGROUND = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND = 1'b1;

   // Input item.
   typedef struct packed {
      logic [ACTION_W-1:0]     action;
      logic [CHAR_W-1:0]       char_code;
      logic [DIR_W-1:0]        direction;
      logic [ADDR_FIELD_W-1:0] cell_address;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [POS_W-1:0]  cursor_position;
      logic [CELL_W-1:0] read_data;
   } rsp_type;

endpackage

// File: design/tcce_ram.sv
// ----------------------------------------------------------------------------
// tcce_ram
// Generic single-clock RAM with one write port and one registered read
// port. A read of the address written at the same edge returns old data.
// ----------------------------------------------------------------------------
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; the read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/text_console_character_engine.sv
// ----------------------------------------------------------------------------
// text_console_character_engine
// Text mode console: a screen memory of attribute/character cells and a
// cursor, driven by put, clear, move and read items.
// ----------------------------------------------------------------------------
// Usage:
//  Items enter on the req_ channel (valid/stall) and each one gives exactly
//  one result on the rsp_ channel: the linear cursor position after the
//  item and, for a read, the cell content (zero otherwise or out of range).
//  The csr_ port sets the foreground and background colour nibbles; write
//  it only while the block is idle.
//  The block works on one item at a time. A put without scroll, a move and
//  a read go from acceptance to the done state, which loads the result
//  register once it is free. A put that reaches the scroll row walks the
//  screen memory through its read port and its write port: it copies each
//  cell of the rows that move up one row higher, then blanks each cell of
//  the last scrolling row. Clear writes one cell per cycle.
//  The result register frees the input side: a new item is accepted while
//  a finished result still waits. If the receiver stalls and the register
//  is full, the next result waits and req_stall stays high.
//  Reset homes the cursor, sets both colours to zero and empties the result
//  register. The screen memory is not cleared: it holds unknown contents
//  until a clear item or cell writes.
// ----------------------------------------------------------------------------
module text_console_character_engine #(
   parameter int COLUMNS      = 80,
   parameter int SCROLL_ROWS  = 24,
   parameter int SCREEN_CELLS = 2000,
   parameter int TAB_WIDTH    = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tcce_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tcce_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write,
   input  logic [tcce_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tcce_pkg::COLOUR_W-1:0]        csr_data
);

   // Sizes derived from the screen geometry.
   localparam int LIMIT    = SCROLL_ROWS * COLUMNS;
   localparam int SPAN     = (LIMIT > SCREEN_CELLS) ? LIMIT : SCREEN_CELLS;
   localparam int COPY_END = (LIMIT < SCREEN_CELLS) ? LIMIT : SCREEN_CELLS;
   localparam int PTR_W    = $clog2(SPAN + 1);
   localparam int ADDR_W   = $clog2(SCREEN_CELLS);
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int NCOL_W   = $clog2(COLUMNS + TAB_WIDTH);
   localparam int ROW_W    = $clog2(SCROLL_ROWS);
   localparam int NROW_W   = $clog2(SCROLL_ROWS + 1);
   localparam int POS_W    = tcce_pkg::POS_W;
   localparam int CELL_W   = tcce_pkg::CELL_W;
   localparam int COLOUR_W = tcce_pkg::COLOUR_W;

   localparam logic [PTR_W-1:0] COPY_START_P  = PTR_W'(COLUMNS);
   localparam logic [PTR_W-1:0] COPY_END_P    = PTR_W'(COPY_END);
   localparam logic [PTR_W-1:0] BLANK_START_P = PTR_W'(LIMIT - COLUMNS);
   localparam logic [PTR_W-1:0] BLANK_LAST_P  = PTR_W'(LIMIT - 1);
   localparam logic [PTR_W-1:0] CLEAR_LAST_P  = PTR_W'(SCREEN_CELLS - 1);
   localparam logic [PTR_W-1:0] CELLS_P       = PTR_W'(SCREEN_CELLS);
   localparam logic [ROW_W-1:0] LAST_ROW_P    = ROW_W'(SCROLL_ROWS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCROLL_COPY,
      ST_SCROLL_BLANK,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Registers and their next values.
   state_type               state_ff, state_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic                    copy_pend_ff, copy_pend_in;
   logic [PTR_W-1:0]        copy_dest_ff, copy_dest_in;
   logic                    read_hit_ff, read_hit_in;
   logic [COLOUR_W-1:0]     fg_ff, fg_in;
   logic [COLOUR_W-1:0]     bg_ff, bg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tcce_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   // Memory port signals.
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [CELL_W-1:0]       wr_data;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [CELL_W-1:0]       rd_data;

   // Put-character decode.
   logic [NCOL_W-1:0]       tab_next;
   logic [NCOL_W-1:0]       put_col;
   logic [NROW_W-1:0]       put_row;
   logic                    put_write;
   logic [tcce_pkg::CHAR_W-1:0] put_byte;
   logic [COL_W-1:0]        put_wcol;
   logic [PTR_W-1:0]        put_idx;
   logic                    put_scroll;

   logic [PTR_W-1:0]        cur_idx;
   logic [CELL_W-1:0]       blank_cell;
   logic                    accept;
   logic                    read_in_range;

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (SCREEN_CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign blank_cell = {bg_ff, fg_ff, tcce_pkg::CHAR_BLANK};
   assign cur_idx    = PTR_W'(int'(row_ff) * COLUMNS + int'(col_ff));
   assign read_in_range = (int'(req_data.cell_address) < SCREEN_CELLS);

   // Next tab stop: the largest multiple of the tab width at or below the
   // column, plus the tab width.
   always_comb begin
      tab_next = '0;
      for (int k = 0; k <= COLUMNS / TAB_WIDTH; k++) begin
         if (int'(col_ff) >= k * TAB_WIDTH) begin
            tab_next = NCOL_W'((k + 1) * TAB_WIDTH);
         end
      end
   end

   // Cursor update and cell write of a put item, then wrap and scroll.
   always_comb begin
      put_col   = NCOL_W'(col_ff);
      put_row   = NROW_W'(row_ff);
      put_write = 1'b0;
      put_byte  = req_data.char_code;
      put_wcol  = col_ff;
      case (req_data.char_code)
         tcce_pkg::CHAR_NEWLINE: begin
            put_col = '0;
            put_row = NROW_W'(row_ff) + 1'b1;
         end
         tcce_pkg::CHAR_RETURN: begin
            put_col = '0;
         end
         tcce_pkg::CHAR_BACKSPACE: begin
            if (col_ff != '0) begin
               put_col   = NCOL_W'(col_ff) - 1'b1;
               put_wcol  = col_ff - 1'b1;
               put_write = 1'b1;
               put_byte  = tcce_pkg::CHAR_BLANK;
            end
         end
         tcce_pkg::CHAR_TAB: begin
            put_col = tab_next;
         end
         default: begin
            if (req_data.char_code inside
                {[tcce_pkg::CHAR_PRINT_LOW:tcce_pkg::CHAR_PRINT_HIGH]}) begin
               put_write = 1'b1;
               put_col   = NCOL_W'(col_ff) + 1'b1;
            end
         end
      endcase
      if (int'(put_col) >= COLUMNS) begin
         put_col = '0;
         put_row = put_row + 1'b1;
      end
      put_scroll = (int'(put_row) >= SCROLL_ROWS);
      put_idx    = PTR_W'(int'(row_ff) * COLUMNS + int'(put_wcol));
   end

   // Sequencer: item decode, memory sweeps and result loading.
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      ptr_in       = ptr_ff;
      copy_pend_in = 1'b0;
      copy_dest_in = copy_dest_ff;
      read_hit_in  = read_hit_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = blank_cell;
      rd_en        = 1'b0;
      rd_addr      = '0;

      // Colour registers.
      if (csr_write) begin
         case (csr_index)
            tcce_pkg::CSR_FOREGROUND: fg_in = csr_data;
            tcce_pkg::CSR_BACKGROUND: bg_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               read_hit_in = 1'b0;
               state_in    = ST_DONE;
               case (req_data.action)
                  tcce_pkg::ACTION_PUT: begin
                     wr_en   = put_write && (put_idx < CELLS_P);
                     wr_addr = put_idx[ADDR_W-1:0];
                     wr_data = {bg_ff, fg_ff, put_byte};
                     if (put_scroll) begin
                        col_in   = '0;
                        row_in   = LAST_ROW_P;
                        ptr_in   = COPY_START_P;
                        state_in = ST_SCROLL_COPY;
                     end else begin
                        col_in = put_col[COL_W-1:0];
                        row_in = put_row[ROW_W-1:0];
                     end
                  end
                  tcce_pkg::ACTION_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     ptr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  tcce_pkg::ACTION_MOVE: begin
                     case (req_data.direction)
                        tcce_pkg::DIR_UP: begin
                           if (row_ff != '0) row_in = row_ff - 1'b1;
                        end
                        tcce_pkg::DIR_DOWN: begin
                           if (int'(row_ff) < SCROLL_ROWS - 1) row_in = row_ff + 1'b1;
                        end
                        tcce_pkg::DIR_LEFT: begin
                           if (col_ff != '0) col_in = col_ff - 1'b1;
                        end
                        tcce_pkg::DIR_RIGHT: begin
                           if (int'(col_ff) < COLUMNS - 1) col_in = col_ff + 1'b1;
                        end
                        default: ;
                     endcase
                  end
                  default: begin
                     rd_en       = read_in_range;
                     rd_addr     = ADDR_W'({{ADDR_W{1'b0}}, req_data.cell_address});
                     read_hit_in = read_in_range;
                  end
               endcase
            end
         end

         // Copy each cell one row up: read it now, write it in the next cycle.
         ST_SCROLL_COPY: begin
            if (copy_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = copy_dest_ff[ADDR_W-1:0];
               wr_data = rd_data;
            end
            if (ptr_ff < COPY_END_P) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_ff[ADDR_W-1:0];
               copy_pend_in = 1'b1;
               copy_dest_in = ptr_ff - COPY_START_P;
               ptr_in       = ptr_ff + 1'b1;
            end else begin
               ptr_in   = BLANK_START_P;
               state_in = ST_SCROLL_BLANK;
            end
         end

         // Fill the last scrolling row with blanks.
         ST_SCROLL_BLANK: begin
            wr_en   = (ptr_ff < CELLS_P);
            wr_addr = ptr_ff[ADDR_W-1:0];
            if (ptr_ff == BLANK_LAST_P) begin
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // Blank every cell of the screen.
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[ADDR_W-1:0];
            if (ptr_ff == CLEAR_LAST_P) begin
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // Load the result once the output register is free.
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.cursor_position = POS_W'({{POS_W{1'b0}}, cur_idx});
               rsp_data_in.read_data       = read_hit_ff ? rd_data : '0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, cursor, colours and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         copy_pend_ff <= 1'b0;
         read_hit_ff  <= 1'b0;
         fg_ff        <= '0;
         bg_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         copy_pend_ff <= copy_pend_in;
         read_hit_ff  <= read_hit_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff       <= ptr_in;
      copy_dest_ff <= copy_dest_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// File: design/tcce_checker.sv
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the text console character engine, bound to the
// top level.
// ----------------------------------------------------------------------------
module tcce_checker #(
   parameter int COLUMNS     = 80,
   parameter int SCROLL_ROWS = 24
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tcce_pkg::rsp_type rsp_data
);

   // A stalled result keeps its item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // No result is shown right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted item keeps the input side busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock)
      !reset && req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while one is at work");

   // A new result is loaded only from the busy final step of an item.
   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item at work");

   // The reported cursor lies on the scrolling part of the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_data.cursor_position) < SCROLL_ROWS * COLUMNS)
      else $error("cursor position out of range");

endmodule

bind text_console_character_engine tcce_checker #(
   .COLUMNS     (COLUMNS),
   .SCROLL_ROWS (SCROLL_ROWS)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: verif/tcce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_scoreboard
// Watches both channels and the colour register port of the console engine.
// It keeps its own copy of the screen, cursor and colours. It predicts the
// result of every accepted item and compares each result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tcce_scoreboard #(
   parameter int COLUMNS      = 80,
   parameter int SCROLL_ROWS  = 24,
   parameter int SCREEN_CELLS = 2000,
   parameter int TAB_WIDTH    = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  tcce_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  tcce_pkg::rsp_type                rsp_data,
   input  logic                             csr_write,
   input  logic [tcce_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcce_pkg::COLOUR_W-1:0]    csr_data,
   output int                               pending,
   output int                               failures
);

   // Predicted console state.
   int                                cursor_col;
   int                                cursor_row;
   logic [tcce_pkg::COLOUR_W-1:0]     fg_colour;
   logic [tcce_pkg::COLOUR_W-1:0]     bg_colour;
   logic [tcce_pkg::CELL_W-1:0]       screen_cells [SCREEN_CELLS];

   tcce_pkg::rsp_type expected_results [$];
   int                mismatch_count = 0;

   // A cell holds the attribute byte (background, foreground) over the character.
   function automatic logic [tcce_pkg::CELL_W-1:0] colour_cell(
         logic [tcce_pkg::CHAR_W-1:0] ch);
      return {bg_colour, fg_colour, ch};
   endfunction

   function automatic void write_cell(int idx, logic [tcce_pkg::CELL_W-1:0] value);
      if (idx < SCREEN_CELLS) begin
         screen_cells[idx] = value;
      end
   endfunction

   // Applies one item to the predicted state and returns its result.
   function automatic tcce_pkg::rsp_type predict_console(tcce_pkg::req_type item);
      tcce_pkg::rsp_type result;
      int      col;
      int      row;
      int      i;
      result = '0;
      col = cursor_col;
      row = cursor_row;
      case (item.action)
         tcce_pkg::ACTION_PUT: begin
            case (item.char_code)
               tcce_pkg::CHAR_NEWLINE: begin
                  col = 0;
                  row++;
               end
               tcce_pkg::CHAR_RETURN: begin
                  col = 0;
               end
               tcce_pkg::CHAR_BACKSPACE: begin
                  // Backspace erases the cell it steps back onto.
                  if (col != 0) begin
                     col--;
                     write_cell(row * COLUMNS + col, colour_cell(tcce_pkg::CHAR_BLANK));
                  end
               end
               tcce_pkg::CHAR_TAB: begin
                  col += TAB_WIDTH - (col % TAB_WIDTH);
               end
               default: begin
                  if (item.char_code >= tcce_pkg::CHAR_PRINT_LOW &&
                      item.char_code <= tcce_pkg::CHAR_PRINT_HIGH) begin
                     write_cell(row * COLUMNS + col, colour_cell(item.char_code));
                     col++;
                  end
               end
            endcase
            if (col >= COLUMNS) begin
               col = 0;
               row++;
            end
            // Scroll: rows move up by one and the bottom text row is blanked.
            if (row >= SCROLL_ROWS) begin
               for (i = COLUMNS; i < SCROLL_ROWS * COLUMNS; i++) begin
                  if (i < SCREEN_CELLS) begin
                     write_cell(i - COLUMNS, screen_cells[i]);
                  end
               end
               for (i = (SCROLL_ROWS - 1) * COLUMNS; i < SCROLL_ROWS * COLUMNS; i++) begin
                  write_cell(i, colour_cell(tcce_pkg::CHAR_BLANK));
               end
               col = 0;
               row = SCROLL_ROWS - 1;
            end
         end
         tcce_pkg::ACTION_CLEAR: begin
            for (i = 0; i < SCREEN_CELLS; i++) begin
               screen_cells[i] = colour_cell(tcce_pkg::CHAR_BLANK);
            end
            col = 0;
            row = 0;
         end
         tcce_pkg::ACTION_MOVE: begin
            case (item.direction)
               tcce_pkg::DIR_UP:    if (row > 0) row--;
               tcce_pkg::DIR_DOWN:  if (row < SCROLL_ROWS - 1) row++;
               tcce_pkg::DIR_LEFT:  if (col > 0) col--;
               tcce_pkg::DIR_RIGHT: if (col < COLUMNS - 1) col++;
               default:   ;
            endcase
         end
         default: begin
            if (item.cell_address < SCREEN_CELLS) begin
               result.read_data = screen_cells[item.cell_address];
            end
         end
      endcase
      cursor_col = col;
      cursor_row = row;
      result.cursor_position = tcce_pkg::POS_W'(row * COLUMNS + col);
      return result;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(string what, int got, int wanted);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, wanted);
      mismatch_count++;
   endtask

   // Results are checked before new predictions are queued, so that a stray
   // result is never matched with an item accepted at the same edge.
   always @(posedge clock) begin
      tcce_pkg::rsp_type want;
      if (reset) begin
         cursor_col = 0;
         cursor_row = 0;
         fg_colour  = '0;
         bg_colour  = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no item waiting", int'(rsp_data), 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.cursor_position !== want.cursor_position) begin
                  report_mismatch("cursor_position", int'(rsp_data.cursor_position),
                                  int'(want.cursor_position));
               end
               if (rsp_data.read_data !== want.read_data) begin
                  report_mismatch("read_data", int'(rsp_data.read_data),
                                  int'(want.read_data));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_console(req_data));
         end
         if (csr_write) begin
            case (csr_index)
               tcce_pkg::CSR_FOREGROUND: fg_colour = csr_data;
               tcce_pkg::CSR_BACKGROUND: bg_colour = csr_data;
               default:        ;
            endcase
         end
      end
      pending  <= expected_results.size();
      failures <= mismatch_count;
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the text console character engine. It opens with
// a directed pass over the special cases of put, move and read. Random bursts
// of text, cursor runs, reads and clears follow under several colour
// settings. Both sides idle in short random bursts but in the last phase.
// The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

   localparam int COLUMNS      = 80;
   localparam int SCROLL_ROWS  = 24;
   localparam int SCREEN_CELLS = 2000;
   localparam int TAB_WIDTH    = 8;
   localparam int PHASE_ITEMS  = 230;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   tcce_pkg::req_type                req_data;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   tcce_pkg::rsp_type                rsp_data;
   logic                             csr_write;
   logic [tcce_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tcce_pkg::COLOUR_W-1:0]    csr_data;

   int   pending;
   int   failures;
   logic quiet = 1'b0;
   int   stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   text_console_character_engine #(
      .COLUMNS      (COLUMNS),
      .SCROLL_ROWS  (SCROLL_ROWS),
      .SCREEN_CELLS (SCREEN_CELLS),
      .TAB_WIDTH    (TAB_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tcce_scoreboard #(
      .COLUMNS      (COLUMNS),
      .SCROLL_ROWS  (SCROLL_ROWS),
      .SCREEN_CELLS (SCREEN_CELLS),
      .TAB_WIDTH    (TAB_WIDTH)
   ) checker_inst (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pending   (pending),
      .failures  (failures)
   );

   // Hard stop far beyond the slowest correct run.
   initial begin
      #60ms;
      $display("tb failed");
      $finish;
   end

   // The result side stalls in random bursts, never in the quiet part.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Presents one item, with an optional idle gap first, and waits for it
   // to be accepted.
   task automatic send_item(tcce_pkg::req_type item);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Directed item; fields that the action does not use carry random values.
   task automatic send_op(logic [tcce_pkg::ACTION_W-1:0] action,
                          logic [tcce_pkg::CHAR_W-1:0] code,
                          logic [tcce_pkg::DIR_W-1:0] dir,
                          logic [tcce_pkg::ADDR_FIELD_W-1:0] addr);
      tcce_pkg::req_type item;
      item.action       = action;
      item.char_code    = (action == tcce_pkg::ACTION_PUT) ? code :
                          tcce_pkg::CHAR_W'($urandom);
      item.direction    = (action == tcce_pkg::ACTION_MOVE) ? dir :
                          tcce_pkg::DIR_W'($urandom);
      item.cell_address = (action == tcce_pkg::ACTION_READ) ? addr :
                          tcce_pkg::ADDR_FIELD_W'($urandom);
      send_item(item);
   endtask

   // Lowers valid and waits until every result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_colours(logic [tcce_pkg::COLOUR_W-1:0] fg,
                              logic [tcce_pkg::COLOUR_W-1:0] bg);
      csr_write <= 1'b1;
      csr_index <= tcce_pkg::CSR_FOREGROUND;
      csr_data  <= fg;
      @(posedge clock);
      csr_index <= tcce_pkg::CSR_BACKGROUND;
      csr_data  <= bg;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Random bursts: runs of text, runs of cursor moves in one direction,
   // groups of reads, and an occasional clear.
   task automatic send_random_phase(int count);
      tcce_pkg::req_type          item;
      int                         kind;
      int                         run;
      int                         pick;
      int                         sent;
      logic [tcce_pkg::DIR_W-1:0] run_dir;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) run = $urandom_range(4, 40);
         else if (kind < 75) run = $urandom_range(1, 40);
         else if (kind < 97) run = $urandom_range(1, 6);
         else run = 1;
         if (run > count - sent) run = count - sent;
         run_dir = tcce_pkg::DIR_W'($urandom_range(0, 3));
         repeat (run) begin
            item.char_code    = tcce_pkg::CHAR_W'($urandom_range(0, 255));
            item.direction    = tcce_pkg::DIR_W'($urandom_range(0, 3));
            item.cell_address = tcce_pkg::ADDR_FIELD_W'($urandom_range(0, 2047));
            if (kind < 55) begin
               item.action = tcce_pkg::ACTION_PUT;
               pick = $urandom_range(0, 99);
               if (pick < 55) item.char_code = tcce_pkg::CHAR_W'($urandom_range(32, 127));
               else if (pick < 67) item.char_code = tcce_pkg::CHAR_NEWLINE;
               else if (pick < 71) item.char_code = tcce_pkg::CHAR_RETURN;
               else if (pick < 78) item.char_code = tcce_pkg::CHAR_BACKSPACE;
               else if (pick < 84) item.char_code = tcce_pkg::CHAR_TAB;
            end else if (kind < 75) begin
               item.action = tcce_pkg::ACTION_MOVE;
               if ($urandom_range(0, 9) != 0) item.direction = run_dir;
            end else if (kind < 97) begin
               item.action = tcce_pkg::ACTION_READ;
            end else begin
               item.action = tcce_pkg::ACTION_CLEAR;
            end
            send_item(item);
            sent++;
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = tcce_pkg::CSR_FOREGROUND;
      csr_data  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_colours(4'hA, 4'h5);

      // Directed part. The screen is cleared first so that no read ever
      // touches a cell that was never written.
      send_op(tcce_pkg::ACTION_CLEAR, 8'h00, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_READ, 8'h00, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_READ, 8'h00, tcce_pkg::DIR_UP, 11'd1999);
      send_op(tcce_pkg::ACTION_READ, 8'h00, tcce_pkg::DIR_UP, 11'd2000);
      send_op(tcce_pkg::ACTION_READ, 8'h00, tcce_pkg::DIR_UP, 11'd2047);
      send_op(tcce_pkg::ACTION_MOVE, 8'h00, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_MOVE, 8'h00, tcce_pkg::DIR_LEFT, 11'd0);
      send_op(tcce_pkg::ACTION_PUT, tcce_pkg::CHAR_BACKSPACE, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_PUT, 8'h41, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_PUT, tcce_pkg::CHAR_PRINT_HIGH, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_PUT, tcce_pkg::CHAR_PRINT_LOW, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_PUT, 8'h80, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_PUT, 8'hFF, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_PUT, 8'h00, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_PUT, 8'h1F, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_PUT, tcce_pkg::CHAR_BACKSPACE, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_READ, 8'h00, tcce_pkg::DIR_UP, 11'd1);
      send_op(tcce_pkg::ACTION_READ, 8'h00, tcce_pkg::DIR_UP, 11'd2);
      send_op(tcce_pkg::ACTION_PUT, tcce_pkg::CHAR_TAB, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_MOVE, 8'h00, tcce_pkg::DIR_RIGHT, 11'd0);
      send_op(tcce_pkg::ACTION_MOVE, 8'h00, tcce_pkg::DIR_DOWN, 11'd0);
      send_op(tcce_pkg::ACTION_PUT, tcce_pkg::CHAR_RETURN, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_PUT, tcce_pkg::CHAR_NEWLINE, tcce_pkg::DIR_UP, 11'd0);
      send_op(tcce_pkg::ACTION_READ, 8'h00, tcce_pkg::DIR_UP, 11'd0);

      // Random phases, each under its own colours; the last one runs
      // without idling on either side.
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         case (phase)
            0:       set_colours(4'h0, 4'h0);
            1:       set_colours(4'hF, 4'hF);
            2:       set_colours(4'h0, 4'hF);
            3:       set_colours(4'hF, 4'h0);
            default: set_colours(tcce_pkg::COLOUR_W'($urandom_range(0, 15)),
                                 tcce_pkg::COLOUR_W'($urandom_range(0, 15)));
         endcase
         if (phase == 5) quiet <= 1'b1;
         send_random_phase(PHASE_ITEMS);
      end

      drain_results();
      repeat (2100) @(posedge clock);
      if (failures == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
